FILE: hdl/mmpc_pkg.sv
`default_nettype none
// ============================================================================
// mmpc_pkg
// Shared types and constants for the motor mixer with pulse clamp.
// ============================================================================
package mmpc_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int CMD_W       = 16;
    localparam int COEF_W      = 16;
    localparam int PULSE_W     = 16;
    localparam int SCALE_W     = 24;
    localparam int ROW_W       = MOTOR_COUNT * COEF_W;
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 6;
    localparam int REG_IDX_W   = 3;

    localparam int PROD_W      = CMD_W + COEF_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int SCALED_W    = SUM_W + SCALE_W + 1;
    localparam int FRAC_BITS   = 38;
    localparam int ROUND_W     = SCALED_W + 1;
    localparam int QUOT_W      = ROUND_W - FRAC_BITS;
    localparam int PULSE_EXT_W = QUOT_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_MIX_ROW_0    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIX_ROW_1    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIX_ROW_2    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIX_ROW_3    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_MIN    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_MAX    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_THRUST_SCALE = 3'd6;

    localparam logic [PULSE_W-1:0] PULSE_MAX_RST = '1;

    typedef logic [MOTOR_COUNT-1:0][CMD_W-1:0]   t_cmd_vec;
    typedef logic [MOTOR_COUNT-1:0][PULSE_W-1:0] t_pulse_vec;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_min;
        logic [PULSE_W-1:0] pulse_max;
        logic [SCALE_W-1:0] scale;
    } t_lane_cfg;

    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

endpackage
`default_nettype wire

FILE: hdl/motor_mixer_pulse_clamp_unit.sv
`default_nettype none
// Registered: lane products, sum, scaled sum, then clamped output.
// Throughput: one transaction per cycle; the pipeline stalls only while a
// result waits at the output register with m_axis_tready low.
// Reset: synchronous, active low; clears valid flags and loads register
// defaults (rows 0, pulse_min 0, pulse_max 65535, thrust_scale 0).
// ============================================================================
// motor_mixer_pulse_clamp_unit
// Four-lane 4x4 motor mixer with thrust scaling and pulse clamp.
// ============================================================================
module motor_mixer_pulse_clamp_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [mmpc_pkg::ADDR_W-1:0]      paddr,
    input  wire  [mmpc_pkg::DATA_W-1:0]      pwdata,
    output logic [mmpc_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // ctrl_thrust, ctrl_roll, ctrl_pitch, ctrl_yaw (16 bits each, low first)
    input  wire  [mmpc_pkg::DATA_W-1:0]      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // pulse_motor_0, pulse_motor_1, pulse_motor_2, pulse_motor_3 (low first)
    output logic [mmpc_pkg::DATA_W-1:0]      m_axis_tdata
);

    logic [mmpc_pkg::ROW_W-1:0]   r_mix_row [mmpc_pkg::MOTOR_COUNT];
    logic [mmpc_pkg::PULSE_W-1:0] r_pulse_min;
    logic [mmpc_pkg::PULSE_W-1:0] r_pulse_max;
    logic [mmpc_pkg::SCALE_W-1:0] r_thrust_scale;
    logic [2:0]                   r_vld;

    logic [mmpc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;
    logic                           pipe_en;
    mmpc_pkg::t_lane_cfg            lane_cfg;
    mmpc_pkg::t_cmd_vec             cmd;
    mmpc_pkg::t_pulse_vec           pulse;
    mmpc_pkg::t_pipe_ctl            merge_ctl;

    assign pready  = 1'b1;
    assign reg_idx = paddr[mmpc_pkg::ADDR_W-1:3];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mmpc_pkg::MOTOR_COUNT; i++) begin
                r_mix_row[i] <= '0;
            end
            r_pulse_min    <= '0;
            r_pulse_max    <= mmpc_pkg::PULSE_MAX_RST;
            r_thrust_scale <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                mmpc_pkg::REG_MIX_ROW_0:    r_mix_row[0]   <= pwdata;
                mmpc_pkg::REG_MIX_ROW_1:    r_mix_row[1]   <= pwdata;
                mmpc_pkg::REG_MIX_ROW_2:    r_mix_row[2]   <= pwdata;
                mmpc_pkg::REG_MIX_ROW_3:    r_mix_row[3]   <= pwdata;
                mmpc_pkg::REG_PULSE_MIN:    r_pulse_min    <= pwdata[mmpc_pkg::PULSE_W-1:0];
                mmpc_pkg::REG_PULSE_MAX:    r_pulse_max    <= pwdata[mmpc_pkg::PULSE_W-1:0];
                mmpc_pkg::REG_THRUST_SCALE: r_thrust_scale <= pwdata[mmpc_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mmpc_pkg::REG_MIX_ROW_0:    prdata = r_mix_row[0];
            mmpc_pkg::REG_MIX_ROW_1:    prdata = r_mix_row[1];
            mmpc_pkg::REG_MIX_ROW_2:    prdata = r_mix_row[2];
            mmpc_pkg::REG_MIX_ROW_3:    prdata = r_mix_row[3];
            mmpc_pkg::REG_PULSE_MIN:    prdata = mmpc_pkg::DATA_W'(r_pulse_min);
            mmpc_pkg::REG_PULSE_MAX:    prdata = mmpc_pkg::DATA_W'(r_pulse_max);
            mmpc_pkg::REG_THRUST_SCALE: prdata = mmpc_pkg::DATA_W'(r_thrust_scale);
            default:                    prdata = '0;
        endcase
    end

    // whole pipeline moves when the output register is free or being drained
    assign pipe_en       = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[1:0], s_axis_tvalid};
        end
    end

    assign lane_cfg.pulse_min = r_pulse_min;
    assign lane_cfg.pulse_max = r_pulse_max;
    assign lane_cfg.scale     = r_thrust_scale;

    assign cmd = s_axis_tdata;

    for (genvar g = 0; g < mmpc_pkg::MOTOR_COUNT; g++) begin : g_lane
        mmpc_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (pipe_en),
            .i_cmd   (cmd),
            .i_row   (r_mix_row[g]),
            .i_cfg   (lane_cfg),
            .o_pulse (pulse[g])
        );
    end

    assign merge_ctl.en  = pipe_en;
    assign merge_ctl.vld = r_vld[2];

    mmpc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (merge_ctl),
        .i_pulse  (pulse),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire

FILE: hdl/mmpc_lane.sv
`default_nettype none
// ============================================================================
// mmpc_lane
// One motor lane: row dot product, thrust scale, rounding, min offset, clamp.
// ============================================================================
module mmpc_lane (
    input  wire                                 i_clk,
    input  wire                                 i_en,
    input  wire mmpc_pkg::t_cmd_vec             i_cmd,
    input  wire [mmpc_pkg::ROW_W-1:0]           i_row,
    input  wire mmpc_pkg::t_lane_cfg            i_cfg,
    output logic [mmpc_pkg::PULSE_W-1:0]        o_pulse
);

    logic signed [mmpc_pkg::PROD_W-1:0]      r_prod [mmpc_pkg::MOTOR_COUNT];
    logic signed [mmpc_pkg::PROD_W-1:0]      n_prod [mmpc_pkg::MOTOR_COUNT];
    logic signed [mmpc_pkg::SUM_W-1:0]       r_sum;
    logic signed [mmpc_pkg::SUM_W-1:0]       n_sum;
    logic signed [mmpc_pkg::SCALED_W-1:0]    r_scaled;
    logic signed [mmpc_pkg::SCALED_W-1:0]    n_scaled;
    logic signed [mmpc_pkg::ROUND_W-1:0]     rounded;
    logic signed [mmpc_pkg::QUOT_W-1:0]      quot;
    logic signed [mmpc_pkg::PULSE_EXT_W-1:0] pulse_ext;
    logic signed [mmpc_pkg::PULSE_EXT_W-1:0] min_ext;
    logic signed [mmpc_pkg::PULSE_EXT_W-1:0] max_ext;

    always_comb begin
        for (int k = 0; k < mmpc_pkg::MOTOR_COUNT; k++) begin
            n_prod[k] = $signed(i_row[k*mmpc_pkg::COEF_W +: mmpc_pkg::COEF_W])
                      * $signed(i_cmd[k]);
        end
    end

    assign n_sum = mmpc_pkg::SUM_W'(r_prod[0]) + mmpc_pkg::SUM_W'(r_prod[1])
                 + mmpc_pkg::SUM_W'(r_prod[2]) + mmpc_pkg::SUM_W'(r_prod[3]);

    assign n_scaled = r_sum * $signed({1'b0, i_cfg.scale});

    // round half up, then drop the fraction
    assign rounded = mmpc_pkg::ROUND_W'(r_scaled)
                   + (mmpc_pkg::ROUND_W'(1) <<< (mmpc_pkg::FRAC_BITS - 1));
    assign quot    = rounded[mmpc_pkg::ROUND_W-1:mmpc_pkg::FRAC_BITS];

    assign min_ext   = $signed({{(mmpc_pkg::PULSE_EXT_W-mmpc_pkg::PULSE_W){1'b0}},
                                i_cfg.pulse_min});
    assign max_ext   = $signed({{(mmpc_pkg::PULSE_EXT_W-mmpc_pkg::PULSE_W){1'b0}},
                                i_cfg.pulse_max});
    assign pulse_ext = mmpc_pkg::PULSE_EXT_W'(quot) + min_ext;

    always_comb begin
        priority if (pulse_ext > max_ext) begin
            o_pulse = i_cfg.pulse_max;
        end else if (pulse_ext < min_ext) begin
            o_pulse = i_cfg.pulse_min;
        end else begin
            o_pulse = pulse_ext[mmpc_pkg::PULSE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < mmpc_pkg::MOTOR_COUNT; k++) begin
                r_prod[k] <= n_prod[k];
            end
            r_sum    <= n_sum;
            r_scaled <= n_scaled;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/mmpc_merge.sv
`default_nettype none
// ============================================================================
// mmpc_merge
// Collects the four lane pulses into one output transaction register.
// ============================================================================
module mmpc_merge (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire mmpc_pkg::t_pipe_ctl       i_ctl,
    input  wire mmpc_pkg::t_pulse_vec      i_pulse,
    output logic                           o_tvalid,
    output logic [mmpc_pkg::DATA_W-1:0]    o_tdata
);

    logic                          r_valid;
    logic [mmpc_pkg::DATA_W-1:0]   r_data;
    logic [mmpc_pkg::DATA_W-1:0]   n_data;

    always_comb begin
        n_data = '0;
        for (int i = 0; i < mmpc_pkg::MOTOR_COUNT; i++) begin
            n_data[i*mmpc_pkg::PULSE_W +: mmpc_pkg::PULSE_W] = i_pulse[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_data <= n_data;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;

endmodule
`default_nettype wire

FILE: tb/motor_mixer_pulse_clamp_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// motor_mixer_pulse_clamp_unit_test
// Self-checking bench for the 4x4 motor mixer with pulse clamp. Mixing rows,
// pulse limits and thrust scale are loaded over APB while the stream is idle.
// A table of directed command vectors runs first, then random vectors across
// several register settings. Every output transaction is compared per motor
// against table values or a bit-exact mixer/rounding/clamp predictor.
// ============================================================================
module motor_mixer_pulse_clamp_unit_test;

    localparam int     PIPE_LAT     = 4;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     RAND_PHASES  = 8;
    localparam int     PHASE_ITEMS  = 180;
    localparam int     N_DIR        = 27;
    localparam longint HALF_TICK    = longint'(1) <<< (mmpc_pkg::FRAC_BITS - 1);
    localparam logic [mmpc_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [3:0][63:0] rows;
        logic [63:0]      pmin;
        logic [63:0]      pmax;
        logic [63:0]      scale;
    } t_reg_set;

    typedef struct packed {
        logic [1:0]           cfg;
        mmpc_pkg::t_cmd_vec   cmd;
        logic                 typed;
        mmpc_pkg::t_pulse_vec want;
    } t_dir_row;

    // rows: {row3, row2, row1, row0}; each row {yaw, pitch, roll, thrust}
    localparam t_reg_set DIR_CFG [0:3] = '{
        '{256'd0, 64'd0, 64'h0000_0000_0000_FFFF, 64'd0},
        '{{64'h4000_C000_4000_4000, 64'hC000_C000_C000_4000,
           64'h4000_4000_C000_4000, 64'hC000_4000_4000_4000},
          64'hDEAD_BEEF_0000_03E8, 64'hFFFF_0000_0000_07D0, 64'h1234_5678_0010_0000},
        '{{64'h0000_7FFF_0000_8000, 64'h7FFF_8000_7FFF_8000,
           64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000},
          64'hFFFF_FFFF_FFFF_0000, 64'h0000_0001_0000_FFFF, 64'hFF00_0000_00FF_FFFF},
        '{{64'h4000_C000_4000_4000, 64'hC000_C000_C000_4000,
           64'h4000_4000_C000_4000, 64'hC000_4000_4000_4000},
          64'h0000_0000_0000_0BB8, 64'h0000_0000_0000_03E8, 64'h0000_0000_0010_0000}
    };

    // cmd: {yaw, pitch, roll, thrust}; want: {m3, m2, m1, m0}
    localparam t_dir_row DIR_TAB [0:N_DIR-1] = '{
        '{2'd0, 64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
        '{2'd0, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1, 64'h0000_0000_0000_0000},
        '{2'd0, 64'h8000_8000_8000_8000, 1'b1, 64'h0000_0000_0000_0000},
        '{2'd1, 64'h0000_0000_0000_0000, 1'b1, 64'h03E8_03E8_03E8_03E8},
        '{2'd1, 64'h0000_0000_0000_7FFF, 1'b1, 64'h07D0_07D0_07D0_07D0},
        '{2'd1, 64'h0000_0000_0000_8000, 1'b1, 64'h03E8_03E8_03E8_03E8},
        '{2'd1, 64'h0000_0000_0000_0100, 1'b0, 64'h0},
        '{2'd1, 64'h0000_0000_0100_2000, 1'b0, 64'h0},
        '{2'd1, 64'h0000_FF00_0000_2000, 1'b0, 64'h0},
        '{2'd1, 64'h0300_0000_0000_2000, 1'b0, 64'h0},
        '{2'd1, 64'h0000_0000_0000_0008, 1'b0, 64'h0},
        '{2'd1, 64'h0000_0000_0000_FFF8, 1'b0, 64'h0},
        '{2'd1, 64'h0000_0000_0000_0007, 1'b0, 64'h0},
        '{2'd1, 64'h0000_0000_0000_FFF7, 1'b0, 64'h0},
        '{2'd1, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0, 64'h0},
        '{2'd1, 64'h8000_8000_8000_8000, 1'b0, 64'h0},
        '{2'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
        '{2'd2, 64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
        '{2'd2, 64'h8000_8000_8000_8000, 1'b0, 64'h0},
        '{2'd2, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0, 64'h0},
        '{2'd2, 64'h7FFF_8000_7FFF_8000, 1'b0, 64'h0},
        '{2'd2, 64'h0001_FFFF_0001_FFFF, 1'b0, 64'h0},
        '{2'd3, 64'h0000_0000_0000_0000, 1'b1, 64'h03E8_03E8_03E8_03E8},
        '{2'd3, 64'h0000_0000_0000_8000, 1'b1, 64'h0BB8_0BB8_0BB8_0BB8},
        '{2'd3, 64'h0000_0000_0000_7FFF, 1'b1, 64'h03E8_03E8_03E8_03E8},
        '{2'd3, 64'h0000_0000_0000_F000, 1'b0, 64'h0},
        '{2'd3, 64'h0000_0000_0000_0010, 1'b0, 64'h0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [mmpc_pkg::ADDR_W-1:0]   paddr;
    logic [mmpc_pkg::DATA_W-1:0]   pwdata;
    logic [mmpc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [mmpc_pkg::DATA_W-1:0]   s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [mmpc_pkg::DATA_W-1:0]   m_axis_tdata;

    logic [3:0][15:0]              row_cfg [mmpc_pkg::MOTOR_COUNT];
    logic [mmpc_pkg::PULSE_W-1:0]  min_cfg;
    logic [mmpc_pkg::PULSE_W-1:0]  max_cfg;
    logic [mmpc_pkg::SCALE_W-1:0]  scale_cfg;

    mmpc_pkg::t_pulse_vec          pulse_q [$];
    int                            err_cnt;
    int                            cycle_cnt;
    bit                            tx_busy_run;
    bit                            rx_busy_run;

    motor_mixer_pulse_clamp_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic mmpc_pkg::t_pulse_vec mix_and_clamp(input mmpc_pkg::t_cmd_vec cmd);
        mmpc_pkg::t_pulse_vec res;
        longint     acc;
        longint     sc;
        longint     q;
        longint     p;
        longint     lo;
        longint     hi;
        shortint    c;
        shortint    u;
        sc = longint'({40'd0, scale_cfg});
        lo = longint'({48'd0, min_cfg});
        hi = longint'({48'd0, max_cfg});
        for (int m = 0; m < mmpc_pkg::MOTOR_COUNT; m++) begin
            acc = 0;
            for (int k = 0; k < mmpc_pkg::MOTOR_COUNT; k++) begin
                c = row_cfg[m][k];
                u = cmd[k];
                acc += longint'(c) * longint'(u);
            end
            q = (acc * sc + HALF_TICK) >>> mmpc_pkg::FRAC_BITS;
            p = lo + q;
            if (p > hi) begin
                res[m] = hi[15:0];
            end else if (p < lo) begin
                res[m] = lo[15:0];
            end else begin
                res[m] = p[15:0];
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        err_cnt++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    task automatic reg_write(input logic [mmpc_pkg::REG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            mmpc_pkg::REG_MIX_ROW_0:    row_cfg[0] = value;
            mmpc_pkg::REG_MIX_ROW_1:    row_cfg[1] = value;
            mmpc_pkg::REG_MIX_ROW_2:    row_cfg[2] = value;
            mmpc_pkg::REG_MIX_ROW_3:    row_cfg[3] = value;
            mmpc_pkg::REG_PULSE_MIN:    min_cfg    = value[mmpc_pkg::PULSE_W-1:0];
            mmpc_pkg::REG_PULSE_MAX:    max_cfg    = value[mmpc_pkg::PULSE_W-1:0];
            mmpc_pkg::REG_THRUST_SCALE: scale_cfg  = value[mmpc_pkg::SCALE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_regs(input t_reg_set rs);
        reg_write(mmpc_pkg::REG_MIX_ROW_0, rs.rows[0]);
        reg_write(mmpc_pkg::REG_MIX_ROW_1, rs.rows[1]);
        reg_write(mmpc_pkg::REG_MIX_ROW_2, rs.rows[2]);
        reg_write(mmpc_pkg::REG_MIX_ROW_3, rs.rows[3]);
        reg_write(mmpc_pkg::REG_PULSE_MIN, rs.pmin);
        reg_write(mmpc_pkg::REG_PULSE_MAX, rs.pmax);
        reg_write(mmpc_pkg::REG_THRUST_SCALE, rs.scale);
        // unmapped index must not disturb anything
        reg_write(REG_UNUSED, {$urandom, $urandom});
    endtask

    // hold the stream until the pipeline has fully drained
    task automatic drain_pipe();
        s_axis_tvalid = 1'b0;
        while (pulse_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 2) @(negedge i_clk);
    endtask

    task automatic send_cmd(input mmpc_pkg::t_cmd_vec cmd, input logic typed,
                            input mmpc_pkg::t_pulse_vec want);
        int gap;
        if ($urandom_range(0, 29) == 0) tx_busy_run = !tx_busy_run;
        gap = tx_busy_run ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = {$urandom, $urandom};
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = cmd;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pulse_q.push_back(typed ? want : mix_and_clamp(cmd));
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_coef();
        logic [15:0] c;
        case ($urandom_range(0, 5))
            0:       c = 16'h0000;
            1:       c = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: c = 16'($urandom_range(0, 16'h4000));
        endcase
        if ($urandom_range(0, 1)) c = -c;
        return c;
    endfunction

    function automatic t_reg_set rand_regs(input int kind);
        t_reg_set    rs;
        logic [15:0] lo;
        logic [15:0] hi;
        for (int m = 0; m < mmpc_pkg::MOTOR_COUNT; m++) begin
            rs.rows[m] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
        end
        lo       = 16'($urandom_range(0, 4000));
        hi       = lo + 16'($urandom_range(0, 4000));
        rs.scale = 64'($urandom_range(0, 24'h40_0000));
        case (kind)
            1: begin
                for (int m = 0; m < mmpc_pkg::MOTOR_COUNT; m++) begin
                    rs.rows[m] = {$urandom, $urandom};
                end
                lo       = 16'($urandom);
                hi       = 16'($urandom);
                rs.scale = {$urandom, $urandom};
            end
            2: begin
                hi = 16'($urandom_range(0, 2000));
                lo = hi + 16'($urandom_range(1, 2000));
            end
            3: begin
                lo = 16'($urandom);
                hi = lo;
            end
            4: begin
                lo       = 16'h0000;
                hi       = 16'hFFFF;
                rs.scale = 64'(24'hFF_FFFF - 24'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        rs.pmin  = {$urandom, 16'($urandom), lo};
        rs.pmax  = {$urandom, 16'($urandom), hi};
        rs.scale = rs.scale | ({$urandom, $urandom} << mmpc_pkg::SCALE_W);
        return rs;
    endfunction

    function automatic mmpc_pkg::t_cmd_vec rand_cmd();
        mmpc_pkg::t_cmd_vec cmd;
        logic [15:0] v;
        int          mag;
        for (int k = 0; k < mmpc_pkg::MOTOR_COUNT; k++) begin
            case ($urandom_range(0, 9))
                0, 1: v = 16'($urandom);
                2: begin
                    case ($urandom_range(0, 3))
                        0:       v = 16'h7FFF;
                        1:       v = 16'h8000;
                        2:       v = 16'h0000;
                        default: v = 16'hFFFF;
                    endcase
                end
                default: begin
                    mag = $urandom_range(4, 13);
                    v   = 16'($urandom_range(0, (1 << mag) - 1));
                    if ($urandom_range(0, 1)) v = -v;
                end
            endcase
            cmd[k] = v;
        end
        return cmd;
    endfunction

    always @(posedge i_clk) begin
        mmpc_pkg::t_pulse_vec want;
        mmpc_pkg::t_pulse_vec got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pulse_q.size() == 0) begin
                flag_mismatch("unexpected result", got, '0);
            end else begin
                want = pulse_q.pop_front();
                for (int m = 0; m < mmpc_pkg::MOTOR_COUNT; m++) begin
                    if (got[m] !== want[m]) begin
                        flag_mismatch($sformatf("pulse_motor_%0d", m), 64'(got[m]),
                                      64'(want[m]));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int stall;
        m_axis_tready = 1'b0;
        rx_busy_run   = 1'b0;
        forever begin
            if ($urandom_range(0, 29) == 0) rx_busy_run = !rx_busy_run;
            stall = rx_busy_run ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && m_axis_tvalid));
            @(negedge i_clk);
        end
    end

    initial begin
        logic [1:0] cur_cfg;
        err_cnt       = 0;
        cycle_cnt     = 0;
        tx_busy_run   = 1'b0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        for (int m = 0; m < mmpc_pkg::MOTOR_COUNT; m++) row_cfg[m] = '0;
        min_cfg   = '0;
        max_cfg   = mmpc_pkg::PULSE_MAX_RST;
        scale_cfg = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        cur_cfg = 2'd0;
        for (int i = 0; i < N_DIR; i++) begin
            if (DIR_TAB[i].cfg != cur_cfg) begin
                drain_pipe();
                cur_cfg = DIR_TAB[i].cfg;
                load_regs(DIR_CFG[cur_cfg]);
            end
            send_cmd(DIR_TAB[i].cmd, DIR_TAB[i].typed, DIR_TAB[i].want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_pipe();
            load_regs(rand_regs(ph % 5));
            repeat (PHASE_ITEMS) send_cmd(rand_cmd(), 1'b0, '0);
        end
        s_axis_tvalid = 1'b0;

        while (pulse_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT * 4) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
